// File: rtl/core/mm_pkg.sv
// ----------------------------------------------------------------------------
// mm_pkg
// Shared types, constants and helpers of the matrix multiply block.
// ----------------------------------------------------------------------------
`default_nettype none

package mm_pkg;

  localparam int MAX_DIM_DEF    = 8;
  localparam int ELEM_WIDTH_DEF = 16;
  localparam int ACC_W          = 35;
  localparam int DIM_W          = 4;
  localparam int IDX_W          = 3;
  localparam int ELEM_PORT_W    = 16;
  localparam int PADDR_W        = 4;
  localparam int PDATA_W        = 32;

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_START  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    REG_A_ROWS = 2'd0,
    REG_A_COLS = 2'd1,
    REG_B_ROWS = 2'd2,
    REG_B_COLS = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_FLUSH,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic [DIM_W-1:0] a_rows;
    logic [DIM_W-1:0] a_cols;
    logic [DIM_W-1:0] b_rows;
    logic [DIM_W-1:0] b_cols;
  } dims_t;

  typedef struct packed {
    logic             issue;
    logic             clr;
    logic             shift;
    logic             busy;
    logic             last;
    logic             mism;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [IDX_W-1:0] k;
  } ctrl_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d,
                                               input logic [DIM_W-1:0] dmax);
    logic [DIM_W-1:0] r;
    r = d;
    if (r == '0) r = DIM_W'(1);
    if (r > dmax) r = dmax;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/mm_cell.sv
// ----------------------------------------------------------------------------
// mm_cell
// One product column: multiply, accumulate, shift result to left neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module mm_cell #(
  parameter int ELEM_WIDTH = mm_pkg::ELEM_WIDTH_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic signed [ELEM_WIDTH-1:0]  a_i,
  input  wire logic signed [ELEM_WIDTH-1:0]  b_i,
  input  wire logic                          valid_i,
  input  wire logic                          clr_i,
  input  wire logic                          shift_i,
  input  wire logic signed [mm_pkg::ACC_W-1:0] nbr_i,
  output logic signed [mm_pkg::ACC_W-1:0]    acc_o
);
  import mm_pkg::*;

  localparam int PW = (2 * ELEM_WIDTH > ACC_W) ? 2 * ELEM_WIDTH : ACC_W;

  logic signed [2*ELEM_WIDTH-1:0] prod_q, prod_d;
  logic                           pv_q;
  logic signed [PW-1:0]           prod_ext;
  logic signed [ACC_W-1:0]        acc_q, acc_d;

  assign prod_d   = a_i * b_i;
  assign prod_ext = PW'(prod_q);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= valid_i;
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (clr_i) begin
      acc_d = '0;
    end else if (shift_i) begin
      acc_d = nbr_i;
    end else if (pv_q) begin
      acc_d = acc_q + prod_ext[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

// File: rtl/core/mm_ctrl.sv
// ----------------------------------------------------------------------------
// mm_ctrl
// Sequencer: walks rows, inner index and drain of the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

module mm_ctrl #(
  parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          go_i,
  input  wire mm_pkg::dims_t dims_i,
  output mm_pkg::ctrl_t      ctrl_o
);
  import mm_pkg::*;

  localparam logic [DIM_W-1:0] DMAX = DIM_W'(MAX_DIM);

  state_e           state_q, state_d;
  logic [IDX_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic             fl_q, fl_d, mism_q, mism_d;
  logic [DIM_W-1:0] ar, ac, br, bc;
  logic             k_end, j_end, i_end;

  assign ar = eff_dim(dims_i.a_rows, DMAX);
  assign ac = eff_dim(dims_i.a_cols, DMAX);
  assign br = eff_dim(dims_i.b_rows, DMAX);
  assign bc = eff_dim(dims_i.b_cols, DMAX);

  assign k_end = (k_q == IDX_W'(ac - DIM_W'(1)));
  assign j_end = (j_q == IDX_W'(bc - DIM_W'(1)));
  assign i_end = (i_q == IDX_W'(ar - DIM_W'(1)));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (go_i) state_d = (ac != br) ? ST_DRAIN : ST_MAC;
      end
      ST_MAC: begin
        if (k_end) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (fl_q) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (j_end) begin
          if (i_end) state_d = ST_IDLE;
          else       state_d = mism_q ? ST_DRAIN : ST_MAC;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    i_d    = i_q;
    j_d    = j_q;
    k_d    = k_q;
    fl_d   = 1'b0;
    mism_d = mism_q;
    ctrl_o = '0;
    ctrl_o.row  = i_q;
    ctrl_o.col  = j_q;
    ctrl_o.k    = k_q;
    ctrl_o.mism = mism_q;
    ctrl_o.busy = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (go_i) begin
          i_d        = '0;
          j_d        = '0;
          k_d        = '0;
          mism_d     = (ac != br);
          ctrl_o.clr = 1'b1;
        end
      end
      ST_MAC: begin
        ctrl_o.issue = 1'b1;
        k_d = k_end ? '0 : k_q + IDX_W'(1);
      end
      ST_FLUSH: begin
        fl_d = ~fl_q;
      end
      ST_DRAIN: begin
        ctrl_o.shift = 1'b1;
        ctrl_o.last  = j_end & i_end;
        if (j_end) begin
          j_d        = '0;
          i_d        = i_q + IDX_W'(1);
          ctrl_o.clr = 1'b1;
        end else begin
          j_d = j_q + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      fl_q    <= 1'b0;
      mism_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      fl_q    <= fl_d;
      mism_q  <= mism_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/matrix_multiply.sv
// ----------------------------------------------------------------------------
// matrix_multiply
// Matrix product over two on-chip element stores and a chain of MAC cells.
// ----------------------------------------------------------------------------
// Load words (operation 0 or 1) keep busy_o low. A start word computes
// C = A * B one row at a time: multiply-accumulate over a_cols inner
// index values in MAX_DIM column cells, a pipeline flush, then the cells
// shift the row out, one word per cycle, b_cols words per row. On a
// dimension mismatch each row is only shifted out, with no
// multiply-accumulate or flush. Results are strobed by result_valid_o
// for one cycle each and cannot be stalled.
`default_nettype none

module matrix_multiply #(
  parameter int MAX_DIM    = mm_pkg::MAX_DIM_DEF,
  parameter int ELEM_WIDTH = mm_pkg::ELEM_WIDTH_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  output logic                                 busy_o,
  input  wire logic [1:0]                      operation_i,
  input  wire logic [mm_pkg::IDX_W-1:0]        row_index_i,
  input  wire logic [mm_pkg::IDX_W-1:0]        col_index_i,
  input  wire logic signed [mm_pkg::ELEM_PORT_W-1:0] element_i,
  output logic                                 result_valid_o,
  output logic [mm_pkg::IDX_W-1:0]             out_row_o,
  output logic [mm_pkg::IDX_W-1:0]             out_col_o,
  output logic signed [mm_pkg::ACC_W-1:0]      product_value_o,
  output logic                                 last_entry_o,
  output logic                                 dims_mismatch_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [mm_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [mm_pkg::PDATA_W-1:0]      pwdata,
  output logic [mm_pkg::PDATA_W-1:0]           prdata,
  output logic                                 pready
);
  import mm_pkg::*;

  localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int LW = (ELEM_WIDTH < ELEM_PORT_W) ? ELEM_WIDTH : ELEM_PORT_W;

  dims_t dims_q, dims_d;
  ctrl_t ctrl;
  logic  accept, idx_ok, we_a, we_b, go, v1_q;
  logic signed [ELEM_WIDTH-1:0] elem;
  logic [IW-1:0] k1_q;

  logic [MAX_DIM-1:0][ELEM_WIDTH-1:0] mem_a [MAX_DIM];
  logic [MAX_DIM-1:0][ELEM_WIDTH-1:0] mem_b [MAX_DIM];
  logic [MAX_DIM-1:0][ELEM_WIDTH-1:0] a_row_q, b_row_q;
  logic signed [ACC_W-1:0] acc_w [MAX_DIM+1];

  // configuration
  assign pready = 1'b1;

  always_comb begin
    dims_d = dims_q;
    if (psel && penable && pwrite) begin
      unique case (reg_e'(paddr[3:2]))
        REG_A_ROWS: dims_d.a_rows = pwdata[DIM_W-1:0];
        REG_A_COLS: dims_d.a_cols = pwdata[DIM_W-1:0];
        REG_B_ROWS: dims_d.b_rows = pwdata[DIM_W-1:0];
        REG_B_COLS: dims_d.b_cols = pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_e'(paddr[3:2]))
      REG_A_ROWS: prdata = PDATA_W'(dims_q.a_rows);
      REG_A_COLS: prdata = PDATA_W'(dims_q.a_cols);
      REG_B_ROWS: prdata = PDATA_W'(dims_q.b_rows);
      REG_B_COLS: prdata = PDATA_W'(dims_q.b_cols);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q <= '{a_rows: DIM_W'(8), a_cols: DIM_W'(8),
                  b_rows: DIM_W'(8), b_cols: DIM_W'(8)};
    end else begin
      dims_q <= dims_d;
    end
  end

  // input word decode
  assign accept = start_i & ~busy_o;
  assign idx_ok = ({1'b0, row_index_i} < (IDX_W + 1)'(MAX_DIM)) &&
                  ({1'b0, col_index_i} < (IDX_W + 1)'(MAX_DIM));
  assign we_a   = accept && idx_ok && (operation_i == OP_LOAD_A);
  assign we_b   = accept && idx_ok && (operation_i == OP_LOAD_B);
  assign go     = accept && (operation_i == OP_START);
  assign elem   = ELEM_WIDTH'(signed'(element_i[LW-1:0]));

  // element stores, one element per load word
  always_ff @(posedge clk_i) begin
    if (we_a) mem_a[row_index_i[IW-1:0]][col_index_i[IW-1:0]] <= elem;
    if (we_b) mem_b[row_index_i[IW-1:0]][col_index_i[IW-1:0]] <= elem;
    a_row_q <= mem_a[ctrl.row[IW-1:0]];
    b_row_q <= mem_b[ctrl.k[IW-1:0]];
    k1_q    <= ctrl.k[IW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= ctrl.issue;
    end
  end

  mm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go),
    .dims_i (dims_q),
    .ctrl_o (ctrl)
  );

  assign acc_w[MAX_DIM] = '0;

  for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
    mm_cell #(.ELEM_WIDTH(ELEM_WIDTH)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .a_i     (signed'(a_row_q[k1_q])),
      .b_i     (signed'(b_row_q[j])),
      .valid_i (v1_q),
      .clr_i   (ctrl.clr),
      .shift_i (ctrl.shift),
      .nbr_i   (acc_w[j+1]),
      .acc_o   (acc_w[j])
    );
  end

  assign busy_o          = ctrl.busy;
  assign result_valid_o  = ctrl.shift;
  assign out_row_o       = ctrl.row;
  assign out_col_o       = ctrl.col;
  assign product_value_o = acc_w[0];
  assign last_entry_o    = ctrl.last;
  assign dims_mismatch_o = ctrl.mism;

endmodule

`default_nettype wire

// File: rtl/core/mm_checker.sv
// ----------------------------------------------------------------------------
// mm_sva
// Port-level checks of the matrix multiply block.
// ----------------------------------------------------------------------------
`default_nettype none

module mm_sva (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       start_i,
  input wire logic                       busy_o,
  input wire logic [1:0]                 operation_i,
  input wire logic                       result_valid_o,
  input wire logic                       last_entry_o,
  input wire logic                       dims_mismatch_o,
  input wire logic [mm_pkg::ACC_W-1:0]   product_value_o
);
  import mm_pkg::*;

  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o) else $error("result outside busy");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_entry_o |=> !busy_o) else $error("busy after last");

  a_more_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_entry_o |=> busy_o) else $error("idle before last");

  a_mism_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && dims_mismatch_o |-> product_value_o == '0)
    else $error("nonzero entry on mismatch");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && operation_i == OP_START |=> busy_o)
    else $error("start not taken");

endmodule

bind matrix_multiply mm_sva u_mm_sva (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .operation_i     (operation_i),
  .result_valid_o  (result_valid_o),
  .last_entry_o    (last_entry_o),
  .dims_mismatch_o (dims_mismatch_o),
  .product_value_o (product_value_o)
);

`default_nettype wire

// File: test/mm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mm_checker
// Watches the command, result and register channels of matrix_multiply,
// predicts the product entries of every accepted start word from its own
// copy of the stores and dimensions, and compares each strobed result
// against the oldest outstanding entry.
// ----------------------------------------------------------------------------
module mm_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic                             busy_i,
  input  logic [1:0]                       operation_i,
  input  logic [mm_pkg::IDX_W-1:0]         row_index_i,
  input  logic [mm_pkg::IDX_W-1:0]         col_index_i,
  input  logic signed [mm_pkg::ELEM_PORT_W-1:0] element_i,
  input  logic                             result_valid_i,
  input  logic [mm_pkg::IDX_W-1:0]         out_row_i,
  input  logic [mm_pkg::IDX_W-1:0]         out_col_i,
  input  logic signed [mm_pkg::ACC_W-1:0]  product_value_i,
  input  logic                             last_entry_i,
  input  logic                             dims_mismatch_i,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mm_pkg::PADDR_W-1:0]       paddr,
  input  logic [mm_pkg::PDATA_W-1:0]       pwdata,
  input  logic                             pready,
  output int                               fail_count_o,
  output int                               pending_o,
  output int                               entry_count_o
);
  import mm_pkg::*;

  localparam int DIM = MAX_DIM_DEF;

  typedef struct {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [ACC_W-1:0] value;
    logic             last;
    logic             mism;
  } entry_t;

  logic signed [15:0] elems_a [DIM*DIM];
  logic signed [15:0] elems_b [DIM*DIM];
  logic [DIM_W-1:0]   dim_reg [4];
  entry_t             product_q [$];

  function automatic int clamp_dim(input logic [DIM_W-1:0] d);
    if (d == 0) return 1;
    if (d > DIM) return DIM;
    return d;
  endfunction

  task automatic expand_product();
    int     nr, nk, nkb, nc;
    longint sum;
    entry_t e;
    nr  = clamp_dim(dim_reg[REG_A_ROWS]);
    nk  = clamp_dim(dim_reg[REG_A_COLS]);
    nkb = clamp_dim(dim_reg[REG_B_ROWS]);
    nc  = clamp_dim(dim_reg[REG_B_COLS]);
    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nc; j++) begin
        sum = 0;
        if (nk == nkb) begin
          for (int k = 0; k < nk; k++)
            sum += longint'(elems_a[i*DIM+k]) * longint'(elems_b[k*DIM+j]);
        end
        e.row   = IDX_W'(i);
        e.col   = IDX_W'(j);
        e.value = sum[ACC_W-1:0];
        e.last  = (i == nr-1) && (j == nc-1);
        e.mism  = (nk != nkb);
        product_q.push_back(e);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    entry_t e;
    if (!rst_ni) begin
      for (int r = 0; r < 4; r++) dim_reg[r] = DIM_W'(8);
      product_q.delete();
      fail_count_o  <= 0;
      entry_count_o <= 0;
    end else begin
      if (psel && penable && pwrite && pready)
        dim_reg[paddr[3:2]] = pwdata[DIM_W-1:0];
      if (start_i && !busy_i) begin
        case (operation_i)
          OP_LOAD_A: elems_a[row_index_i*DIM+col_index_i] = element_i;
          OP_LOAD_B: elems_b[row_index_i*DIM+col_index_i] = element_i;
          OP_START:  expand_product();
          default: ;
        endcase
      end
      if (result_valid_i) begin
        entry_count_o <= entry_count_o + 1;
        if (product_q.size() == 0) begin
          $display("%0t: unexpected word row %0d col %0d value %0d", $time,
                   out_row_i, out_col_i, product_value_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = product_q.pop_front();
          if (e.row !== out_row_i || e.col !== out_col_i ||
              e.value !== product_value_i || e.last !== last_entry_i ||
              e.mism !== dims_mismatch_i) begin
            $display("%0t: mismatch exp row %0d col %0d value %h last %b mism %b",
                     $time, e.row, e.col, e.value, e.last, e.mism);
            $display("%0t:          got row %0d col %0d value %h last %b mism %b",
                     $time, out_row_i, out_col_i, product_value_i, last_entry_i,
                     dims_mismatch_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
    pending_o <= product_q.size();
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives matrix_multiply with directed and random load and start words
// under several dimension settings, with random gaps; a checker beside
// the block predicts and compares every product entry.
// ----------------------------------------------------------------------------
module tb;
  import mm_pkg::*;

  localparam int DIM   = MAX_DIM_DEF;
  localparam int LIMIT = 3000;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic start_i = 0;
  logic [1:0] operation_i = '0;
  logic [IDX_W-1:0] row_index_i = '0, col_index_i = '0;
  logic signed [ELEM_PORT_W-1:0] element_i = '0;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic busy_o, result_valid_o, last_entry_o, dims_mismatch_o, pready;
  logic [IDX_W-1:0] out_row_o, out_col_o;
  logic signed [ACC_W-1:0] product_value_o;
  logic [PDATA_W-1:0] prdata;

  int fails, pending, entries;
  logic taken_q = 0;
  int idle_cycles = 0;
  int words = 0, starts = 0;
  bit written_a [DIM*DIM];
  bit written_b [DIM*DIM];
  logic [DIM_W-1:0] dims [4];
  bit no_gaps;

  always #5 clk_i = ~clk_i;

  matrix_multiply uut (.*);

  mm_checker chk (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .operation_i, .row_index_i,
    .col_index_i, .element_i, .result_valid_i(result_valid_o), .out_row_i(out_row_o),
    .out_col_i(out_col_o), .product_value_i(product_value_o),
    .last_entry_i(last_entry_o), .dims_mismatch_i(dims_mismatch_o), .psel, .penable,
    .pwrite, .paddr, .pwdata, .pready, .fail_count_o(fails), .pending_o(pending),
    .entry_count_o(entries)
  );

  always @(posedge clk_i) begin
    taken_q <= start_i && !busy_o;
    if (!rst_ni || (start_i && !busy_o) || result_valid_o || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= LIMIT) begin
      $display("timeout after %0d idle cycles", LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int clamp_dim(input logic [DIM_W-1:0] d);
    if (d == 0) return 1;
    if (d > DIM) return DIM;
    return d;
  endfunction

  task automatic gap();
    int n;
    n = $urandom_range(0, 19);
    if (no_gaps || n < 12) return;
    start_i = 0;
    repeat (n < 18 ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(negedge clk_i);
  endtask

  task automatic send_word(input logic [1:0] op, input int r, input int c,
                           input logic [15:0] v);
    gap();
    operation_i = op;
    row_index_i = IDX_W'(r);
    col_index_i = IDX_W'(c);
    element_i   = v;
    start_i     = 1;
    do @(negedge clk_i); while (!taken_q);
    words++;
    if (op == OP_LOAD_A) written_a[r*DIM+c] = 1;
    if (op == OP_LOAD_B) written_b[r*DIM+c] = 1;
    if (op == OP_START) starts++;
  endtask

  task automatic drain();
    start_i = 0;
    do @(negedge clk_i); while (pending != 0 || busy_o || taken_q);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_dim(input reg_e idx, input logic [DIM_W-1:0] v);
    psel = 1; penable = 0; pwrite = 1;
    paddr = PADDR_W'(4 * idx); pwdata = PDATA_W'(v);
    @(negedge clk_i);
    penable = 1;
    @(negedge clk_i);
    psel = 0; penable = 0; pwrite = 0;
    dims[idx] = v;
  endtask

  // every store entry the next start reads gets written first
  task automatic start_product();
    int nr, nk, nkb, nc;
    nr  = clamp_dim(dims[REG_A_ROWS]);
    nk  = clamp_dim(dims[REG_A_COLS]);
    nkb = clamp_dim(dims[REG_B_ROWS]);
    nc  = clamp_dim(dims[REG_B_COLS]);
    if (nk == nkb) begin
      for (int i = 0; i < nr; i++)
        for (int k = 0; k < nk; k++)
          if (!written_a[i*DIM+k]) send_word(OP_LOAD_A, i, k, 16'($urandom));
      for (int k = 0; k < nk; k++)
        for (int j = 0; j < nc; j++)
          if (!written_b[k*DIM+j]) send_word(OP_LOAD_B, k, j, 16'($urandom));
    end
    send_word(OP_START, 0, 0, 16'($urandom));
  endtask

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 7))
      0: return DIM_W'(0);
      1: return DIM_W'(15);
      2: return DIM_W'(8);
      3: return DIM_W'(1);
      default: return DIM_W'($urandom_range(1, 4));
    endcase
  endfunction

  initial begin
    logic [1:0] op;
    for (int r = 0; r < 4; r++) dims[r] = DIM_W'(8);
    repeat (11) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // directed: extremes on 2x2, noise word, a mismatch, then clamped dimensions
    no_gaps = 1;
    write_dim(REG_A_ROWS, DIM_W'(2)); write_dim(REG_A_COLS, DIM_W'(2));
    write_dim(REG_B_ROWS, DIM_W'(2)); write_dim(REG_B_COLS, DIM_W'(2));
    send_word(OP_LOAD_A, 0, 0, 16'h7fff); send_word(OP_LOAD_A, 0, 1, 16'h8000);
    send_word(OP_LOAD_A, 1, 0, 16'h8000); send_word(OP_LOAD_A, 1, 1, 16'h8000);
    send_word(OP_LOAD_B, 0, 0, 16'h8000); send_word(OP_LOAD_B, 0, 1, 16'h7fff);
    send_word(OP_LOAD_B, 1, 0, 16'h8000); send_word(OP_LOAD_B, 1, 1, 16'h8000);
    send_word(2'd3, 7, 7, 16'hffff);
    send_word(OP_LOAD_A, 7, 7, 16'h0001);
    send_word(OP_START, 7, 7, 16'h0000);
    drain();
    write_dim(REG_B_ROWS, DIM_W'(3));
    send_word(OP_START, 0, 0, 16'h1234);
    drain();
    write_dim(REG_A_ROWS, DIM_W'(0)); write_dim(REG_A_COLS, DIM_W'(15));
    write_dim(REG_B_ROWS, DIM_W'(9)); write_dim(REG_B_COLS, DIM_W'(0));
    send_word(OP_START, 0, 0, 16'h0000);
    drain();

    while (words < 520) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      write_dim(REG_A_ROWS, pick_dim()); write_dim(REG_A_COLS, pick_dim());
      write_dim(REG_B_COLS, pick_dim());
      write_dim(REG_B_ROWS, $urandom_range(0, 4) == 0 ? pick_dim() : dims[REG_A_COLS]);
      repeat ($urandom_range(2, 6)) begin
        repeat ($urandom_range(0, 12)) begin
          op = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 1));
          send_word(op, $urandom_range(0, 7), $urandom_range(0, 7), 16'($urandom));
        end
        start_product();
      end
      drain();
    end

    drain();
    repeat (20) @(negedge clk_i);
    $display("covered %0d words, %0d products, %0d entries checked", words, starts,
             entries);
    $display("dimension settings from 0 to 15, mismatches and full 8x8 included");
    if (fails == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: matrix_multiply.f
rtl/core/mm_pkg.sv
rtl/core/mm_cell.sv
rtl/core/mm_ctrl.sv
rtl/core/matrix_multiply.sv
rtl/core/mm_checker.sv
test/mm_checker.sv
test/tb.sv
